// File: hdl/cht_pkg.sv
package cht_pkg;

    typedef enum logic [1:0] {
        OP_FIND   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISS    = 2'd1,
        ST_DUP     = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_NODE,
        S_CHECK,
        S_POP,
        S_INS,
        S_DEL,
        S_OUT
    } t_state;

endpackage

// File: hdl/cht_ram.sv
module cht_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: hdl/chained_hash_table_top.sv
// Hash table of unique 32-bit keys with 32-bit payloads, chained by bucket
// (key modulo BUCKETS) over a pool of POOL_NODES nodes. One request is taken
// at a time and gives one result beat. After the accepting cycle a request
// forms the bucket index, reads the bucket head, visits each chain node with
// a node read and a check, checks once more when the walk ends without a
// match, unlinks the node for a delete or pops a free node and links it for
// an insert, and loads the result register; the next request can be accepted
// in the cycle after that. Each node visit is a read of the node memories.
// A result beat that is not taken stalls the engine only once the next result
// is ready. After reset a clearing pass over max(BUCKETS, POOL_NODES) entries
// sets the bucket heads and the free stack, during which no request is
// accepted.
module chained_hash_table_top #(
    parameter int BUCKETS    = 256,
    parameter int POOL_NODES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // key[31:0], payload[63:32]
    input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // payload_out[31:0]
    output logic [1:0]  m_axis_tuser   // status[1:0]
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NW = $clog2(POOL_NODES);
    localparam int PW = NW + 1;
    localparam int CLR = (BUCKETS > POOL_NODES) ? BUCKETS : POOL_NODES;
    localparam int CW = $clog2(CLR + 1);
    localparam logic [PW-1:0] NIL = PW'(POOL_NODES);
    localparam bit POW2 = (BUCKETS == (1 << BW));
    localparam logic [32:0] RM = 33'(((64'd1 << (32 + BW)) / 64'(BUCKETS)) + 64'd1);

    cht_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_clr, n_clr;
    cht_pkg::t_opcode r_op, n_op;
    logic [31:0]     r_key, n_key, r_data, n_data;
    logic [PW-1:0]   r_cur, n_cur, r_prev, n_prev, r_nxt, n_nxt;
    logic [PW-1:0]   r_cnt, n_cnt;
    logic [1:0]      r_st, n_st;
    logic [31:0]     r_res, n_res;
    logic            r_ovld, n_ovld;
    logic [31:0]     r_q, n_q;
    logic [BW-1:0]   r_bkt, n_bkt;
    logic [1:0]      r_ost, n_ost;
    logic [31:0]     r_ores, n_ores;

    logic [64:0]   key_prod;
    logic          hb_we, nk_we, fs_we;
    logic [BW-1:0] hb_wa;
    logic [PW-1:0] hb_wd, hb_rd, nn_wd, nn_rd;
    logic [NW-1:0] nn_wa, nk_wa, n_ra, fs_wa, fs_ra, fs_wd, fs_rd;
    logic          nn_we;
    logic [31:0]   nk_rd, np_rd;

    // The quotient of the key by BUCKETS comes from a multiply by a rounded-up
    // reciprocal; the bucket is the key minus that quotient times BUCKETS.
    always_comb begin
        key_prod = 65'(s_axis_tdata[31:0]) * 65'(RM);
    end

    cht_ram #(.DEPTH(BUCKETS), .WIDTH(PW)) u_head (
        .i_clk(i_clk), .i_we(hb_we), .i_waddr(hb_wa), .i_wdata(hb_wd),
        .i_raddr(n_bkt), .o_rdata(hb_rd));
    cht_ram #(.DEPTH(POOL_NODES), .WIDTH(32)) u_key (
        .i_clk(i_clk), .i_we(nk_we), .i_waddr(nk_wa), .i_wdata(r_key),
        .i_raddr(n_ra), .o_rdata(nk_rd));
    cht_ram #(.DEPTH(POOL_NODES), .WIDTH(32)) u_pay (
        .i_clk(i_clk), .i_we(nk_we), .i_waddr(nk_wa), .i_wdata(r_data),
        .i_raddr(n_ra), .o_rdata(np_rd));
    cht_ram #(.DEPTH(POOL_NODES), .WIDTH(PW)) u_next (
        .i_clk(i_clk), .i_we(nn_we), .i_waddr(nn_wa), .i_wdata(nn_wd),
        .i_raddr(n_ra), .o_rdata(nn_rd));
    cht_ram #(.DEPTH(POOL_NODES), .WIDTH(NW)) u_free (
        .i_clk(i_clk), .i_we(fs_we), .i_waddr(fs_wa), .i_wdata(fs_wd),
        .i_raddr(fs_ra), .o_rdata(fs_rd));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cht_pkg::S_CLEAR;
            r_clr   <= '0;
            r_cnt   <= NIL;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_cnt   <= n_cnt;
            r_ovld  <= n_ovld;
        end
        r_op <= n_op; r_key <= n_key; r_data <= n_data;
        r_cur <= n_cur; r_prev <= n_prev; r_nxt <= n_nxt;
        r_st <= n_st; r_res <= n_res;
        r_q <= n_q; r_bkt <= n_bkt;
        r_ost <= n_ost; r_ores <= n_ores;
    end

    always_comb begin
        n_state = r_state; n_clr = r_clr; n_op = r_op; n_key = r_key;
        n_data = r_data; n_cur = r_cur; n_prev = r_prev; n_nxt = r_nxt;
        n_cnt = r_cnt; n_st = r_st; n_res = r_res; n_ovld = r_ovld;
        n_q = r_q; n_bkt = r_bkt; n_ost = r_ost; n_ores = r_ores;
        hb_we = 1'b0; hb_wa = r_bkt; hb_wd = NIL;
        nk_we = 1'b0; nk_wa = r_cur[NW-1:0];
        nn_we = 1'b0; nn_wa = r_cur[NW-1:0]; nn_wd = r_nxt;
        fs_we = 1'b0; fs_wa = r_cnt[NW-1:0]; fs_wd = r_cur[NW-1:0];
        fs_ra = NW'(r_cnt - PW'(1));
        n_ra = r_cur[NW-1:0];
        s_axis_tready = 1'b0;
        if (m_axis_tready) begin
            n_ovld = 1'b0;
        end
        case (r_state)
            cht_pkg::S_CLEAR: begin
                if (r_clr < CW'(BUCKETS)) begin
                    hb_we = 1'b1;
                    hb_wa = BW'(r_clr);
                end
                if (r_clr < CW'(POOL_NODES)) begin
                    fs_we = 1'b1;
                    fs_wa = NW'(r_clr);
                    fs_wd = NW'(CW'(POOL_NODES - 1) - r_clr);
                end
                n_clr = r_clr + CW'(1);
                if (r_clr == CW'(CLR - 1)) begin
                    n_state = cht_pkg::S_IDLE;
                end
            end
            cht_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_op    = cht_pkg::t_opcode'(s_axis_tuser);
                    n_key   = s_axis_tdata[31:0];
                    n_data  = s_axis_tdata[63:32];
                    n_q     = 32'(key_prod >> (32 + BW));
                    n_prev  = NIL;
                    n_state = cht_pkg::S_HASH;
                end
            end
            cht_pkg::S_HASH: begin
                n_bkt = POW2 ? r_key[BW-1:0] : BW'(r_key - r_q * 32'(BUCKETS));
                n_state = cht_pkg::S_HEAD;
            end
            cht_pkg::S_HEAD: begin
                n_cur = hb_rd;
                n_state = (hb_rd == NIL) ? cht_pkg::S_CHECK : cht_pkg::S_NODE;
            end
            cht_pkg::S_NODE: begin
                n_state = cht_pkg::S_CHECK;
            end
            cht_pkg::S_CHECK: begin
                n_nxt = nn_rd;
                n_res = '0;
                if (r_cur != NIL && nk_rd == r_key) begin
                    n_res = np_rd;
                    case (r_op)
                        cht_pkg::OP_FIND: begin
                            n_st = cht_pkg::ST_OK;
                            n_state = cht_pkg::S_OUT;
                        end
                        cht_pkg::OP_INSERT: begin
                            n_st = cht_pkg::ST_DUP;
                            n_res = '0;
                            n_state = cht_pkg::S_OUT;
                        end
                        cht_pkg::OP_DELETE: begin
                            n_st = cht_pkg::ST_OK;
                            n_state = cht_pkg::S_DEL;
                        end
                        default: begin
                            n_st = cht_pkg::ST_MISS;
                            n_res = '0;
                            n_state = cht_pkg::S_OUT;
                        end
                    endcase
                end else if (r_cur != NIL) begin
                    n_prev = r_cur;
                    n_cur = nn_rd;
                    n_ra = nn_rd[NW-1:0];
                    n_state = (nn_rd == NIL) ? cht_pkg::S_CHECK : cht_pkg::S_NODE;
                    if (nn_rd == NIL) begin
                        n_cur = NIL;
                    end
                end else if (r_op == cht_pkg::OP_INSERT) begin
                    if (r_cnt == '0) begin
                        n_st = cht_pkg::ST_FULL;
                        n_state = cht_pkg::S_OUT;
                    end else begin
                        n_state = cht_pkg::S_POP;
                    end
                end else begin
                    n_st = cht_pkg::ST_MISS;
                    n_state = cht_pkg::S_OUT;
                end
            end
            cht_pkg::S_POP: begin
                n_cur = {1'b0, fs_rd};
                n_cnt = r_cnt - PW'(1);
                n_state = cht_pkg::S_INS;
            end
            cht_pkg::S_INS: begin
                nk_we = 1'b1;
                nn_we = 1'b1;
                nn_wd = hb_rd;
                hb_we = 1'b1;
                hb_wd = r_cur;
                n_st = cht_pkg::ST_OK;
                n_res = '0;
                n_state = cht_pkg::S_OUT;
            end
            cht_pkg::S_DEL: begin
                if (r_prev == NIL) begin
                    hb_we = 1'b1;
                    hb_wd = r_nxt;
                end else begin
                    nn_we = 1'b1;
                    nn_wa = r_prev[NW-1:0];
                end
                fs_we = 1'b1;
                n_cnt = r_cnt + PW'(1);
                n_state = cht_pkg::S_OUT;
            end
            cht_pkg::S_OUT: begin
                if (!r_ovld || m_axis_tready) begin
                    n_ovld = 1'b1;
                    n_ost = r_st;
                    n_ores = r_res;
                    n_state = cht_pkg::S_IDLE;
                end
            end
            default: n_state = cht_pkg::S_IDLE;
        endcase
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_ores;
    assign m_axis_tuser  = r_ost;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NIL) else $error("free count out of range");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == cht_pkg::S_IDLE)
        else $error("ready outside idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped");

endmodule
